// ===== rtl/i2cm_pkg.sv =====
package i2cm_pkg;

   // write buffer
   localparam int BufDepth = 16;
   localparam int BufIdxW  = (BufDepth > 1) ? $clog2(BufDepth) : 1;
   localparam int PtrW     = $clog2(BufDepth + 1);

   // word field widths
   localparam int ReqTypeW = 2;
   localparam int AddrW    = 7;
   localparam int CountW   = 5;
   localparam int ByteW    = 8;
   localparam int BitCntW  = 3;
   localparam int StepW    = 6;

   // request codes
   localparam logic [ReqTypeW-1:0] REQ_LOAD     = 2'd0;
   localparam logic [ReqTypeW-1:0] REQ_START    = 2'd1;
   localparam logic [ReqTypeW-1:0] REQ_BUS_STEP = 2'd2;

   localparam logic [BitCntW-1:0] LAST_BIT = 3'd7;

   // microprogram step addresses
   localparam logic [StepW-1:0] ST_IDLE        = 6'd0;
   localparam logic [StepW-1:0] ST_EMPTY       = 6'd1;
   localparam logic [StepW-1:0] ST_WBASE       = 6'd2;
   localparam logic [StepW-1:0] ST_RBASE       = 6'd16;
   localparam logic [StepW-1:0] ST_RD_STOP     = 6'd26;
   localparam logic [StepW-1:0] ST_RXH         = 6'd30;
   localparam logic [StepW-1:0] ST_RXL         = 6'd31;
   localparam logic [StepW-1:0] ST_ACK_SDA     = 6'd32;
   localparam logic [StepW-1:0] ST_ACK_SCL_HI  = 6'd33;
   localparam logic [StepW-1:0] ST_ACK_SCL_LO  = 6'd34;
   localparam logic [StepW-1:0] ST_ACK_REL     = 6'd35;
   localparam logic [StepW-1:0] ST_NAK_SDA     = 6'd36;
   localparam logic [StepW-1:0] ST_NAK_SCL_HI  = 6'd37;
   localparam logic [StepW-1:0] ST_NAK_SCL_LO  = 6'd38;
   localparam logic [StepW-1:0] ST_NAK_REL     = 6'd39;

   // offsets inside an address/data segment
   localparam logic [StepW-1:0] OFS_SDA_HI      = 6'd0;
   localparam logic [StepW-1:0] OFS_SCL_HI      = 6'd1;
   localparam logic [StepW-1:0] OFS_START       = 6'd2;
   localparam logic [StepW-1:0] OFS_START_SCL   = 6'd3;
   localparam logic [StepW-1:0] OFS_BIT_SDA     = 6'd4;
   localparam logic [StepW-1:0] OFS_BIT_SCL_HI  = 6'd5;
   localparam logic [StepW-1:0] OFS_BIT_SCL_LO  = 6'd6;
   localparam logic [StepW-1:0] OFS_ACK_REL     = 6'd7;
   localparam logic [StepW-1:0] OFS_ACK_SCL_HI  = 6'd8;
   localparam logic [StepW-1:0] OFS_ACK_SCL_LO  = 6'd9;
   localparam logic [StepW-1:0] OFS_STOP_SCL_LO = 6'd10;
   localparam logic [StepW-1:0] OFS_STOP_SDA_LO = 6'd11;
   localparam logic [StepW-1:0] OFS_STOP_SCL_HI = 6'd12;
   localparam logic [StepW-1:0] OFS_STOP_SDA_HI = 6'd13;

   typedef enum logic [1:0] {SCL_HOLD, SCL_LOW, SCL_HIGH} scl_src_type;
   typedef enum logic [1:0] {SDA_HOLD, SDA_LOW, SDA_HIGH, SDA_MSB} sda_src_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_EMPTY_DONE,
      OP_BIT,
      OP_ACK_SAMPLE,
      OP_WR_DECIDE,
      OP_RD_DECIDE,
      OP_WR_STOP,
      OP_RD_STOP,
      OP_RX_SHIFT,
      OP_RX_BYTE
   } op_type;

   typedef enum logic [1:0] {BR_NEXT, BR_JUMP, BR_ALT} br_sel_type;

   typedef struct packed {
      scl_src_type      scl;
      sda_src_type      sda;
      op_type           op;
      logic [StepW-1:0] next_step;
      logic [StepW-1:0] jump_step;
      logic [StepW-1:0] alt_step;
   } ctrl_word_type;

   typedef struct packed {
      br_sel_type       br_sel;
      logic             start_en;
      logic [StepW-1:0] start_step;
   } dp_status_type;

   typedef struct packed {
      logic             scl_level;
      logic             sda_level;
      logic [ByteW-1:0] rx_byte;
      logic             rx_valid;
      logic             done_res;
      logic             nack;
   } rsp_word_type;

   // control store
   function automatic ctrl_word_type ucode_rom(input logic [StepW-1:0] step);
      ctrl_word_type    cw;
      logic             rd_side;
      logic [StepW-1:0] base;
      logic [StepW-1:0] off;
      cw.scl       = SCL_HOLD;
      cw.sda       = SDA_HOLD;
      cw.op        = OP_NONE;
      cw.next_step = ST_IDLE;
      cw.jump_step = ST_IDLE;
      cw.alt_step  = ST_IDLE;
      rd_side      = (step >= ST_RBASE);
      base         = rd_side ? ST_RBASE : ST_WBASE;
      off          = step - base;
      if (step >= ST_WBASE && step < ST_RXH) begin
         cw.next_step = step + StepW'(1);
         unique case (off)
            OFS_SDA_HI:      cw.sda = SDA_HIGH;
            OFS_SCL_HI:      cw.scl = SCL_HIGH;
            OFS_START:       cw.sda = SDA_LOW;
            OFS_START_SCL:   cw.scl = SCL_LOW;
            OFS_BIT_SDA:     cw.sda = SDA_MSB;
            OFS_BIT_SCL_HI:  cw.scl = SCL_HIGH;
            OFS_BIT_SCL_LO: begin
               cw.scl       = SCL_LOW;
               cw.op        = OP_BIT;
               cw.next_step = base + OFS_BIT_SDA;
               cw.jump_step = base + OFS_ACK_REL;
            end
            OFS_ACK_REL:     cw.sda = SDA_HIGH;
            OFS_ACK_SCL_HI: begin
               cw.scl = SCL_HIGH;
               cw.op  = OP_ACK_SAMPLE;
            end
            OFS_ACK_SCL_LO: begin
               cw.scl = SCL_LOW;
               if (rd_side) begin
                  cw.op        = OP_RD_DECIDE;
                  cw.next_step = ST_NAK_SDA;
                  cw.jump_step = ST_RXH;
               end else begin
                  cw.op        = OP_WR_DECIDE;
                  cw.jump_step = base + OFS_BIT_SDA;
               end
            end
            OFS_STOP_SCL_LO: cw.scl = SCL_LOW;
            OFS_STOP_SDA_LO: cw.sda = SDA_LOW;
            OFS_STOP_SCL_HI: cw.scl = SCL_HIGH;
            default: begin
               // stop condition completes
               cw.sda       = SDA_HIGH;
               cw.op        = rd_side ? OP_RD_STOP : OP_WR_STOP;
               cw.next_step = ST_IDLE;
               cw.jump_step = ST_RBASE;
            end
         endcase
      end else begin
         unique case (step)
            ST_EMPTY: cw.op = OP_EMPTY_DONE;
            ST_RXH: begin
               cw.scl       = SCL_HIGH;
               cw.op        = OP_RX_SHIFT;
               cw.next_step = ST_RXL;
            end
            ST_RXL: begin
               cw.scl       = SCL_LOW;
               cw.op        = OP_RX_BYTE;
               cw.next_step = ST_NAK_SDA;
               cw.jump_step = ST_ACK_SDA;
               cw.alt_step  = ST_RXH;
            end
            ST_ACK_SDA: begin
               cw.sda       = SDA_LOW;
               cw.next_step = ST_ACK_SCL_HI;
            end
            ST_ACK_SCL_HI: begin
               cw.scl       = SCL_HIGH;
               cw.next_step = ST_ACK_SCL_LO;
            end
            ST_ACK_SCL_LO: begin
               cw.scl       = SCL_LOW;
               cw.next_step = ST_ACK_REL;
            end
            ST_ACK_REL: begin
               cw.sda       = SDA_HIGH;
               cw.next_step = ST_RXH;
            end
            ST_NAK_SDA: begin
               cw.sda       = SDA_HIGH;
               cw.next_step = ST_NAK_SCL_HI;
            end
            ST_NAK_SCL_HI: begin
               cw.scl       = SCL_HIGH;
               cw.next_step = ST_NAK_SCL_LO;
            end
            ST_NAK_SCL_LO: begin
               cw.scl       = SCL_LOW;
               cw.next_step = ST_NAK_REL;
            end
            ST_NAK_REL: begin
               cw.sda       = SDA_HIGH;
               cw.next_step = ST_RD_STOP;
            end
            default: ;
         endcase
      end
      return cw;
   endfunction

endpackage

// ===== rtl/i2cm_ifs.sv =====
interface i2cm_req_if;
   import i2cm_pkg::*;

   logic                valid;
   logic                ready;
   logic [ReqTypeW-1:0] req_type;
   logic [AddrW-1:0]    slave_addr;
   logic [CountW-1:0]   write_count;
   logic [CountW-1:0]   read_count;
   logic [ByteW-1:0]    write_byte;
   logic                sda_in;

   modport source (
      output valid, req_type, slave_addr, write_count, read_count, write_byte, sda_in,
      input  ready
   );
   modport sink (
      input  valid, req_type, slave_addr, write_count, read_count, write_byte, sda_in,
      output ready
   );
endinterface

interface i2cm_rsp_if;
   import i2cm_pkg::*;

   logic             valid;
   logic             ready;
   logic             scl_level;
   logic             sda_level;
   logic [ByteW-1:0] rx_byte;
   logic             rx_valid;
   logic             done_res;
   logic             nack;

   modport source (
      output valid, scl_level, sda_level, rx_byte, rx_valid, done_res, nack,
      input  ready
   );
   modport sink (
      input  valid, scl_level, sda_level, rx_byte, rx_valid, done_res, nack,
      output ready
   );
endinterface

// ===== rtl/i2cm_seq.sv =====
module i2cm_seq (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         do_step,
   input  i2cm_pkg::dp_status_type      status,
   output i2cm_pkg::ctrl_word_type      cw,
   output logic                         seq_idle
);
   import i2cm_pkg::*;

   logic [StepW-1:0] step_ff;
   logic [StepW-1:0] step_in;
   logic [StepW-1:0] branch_step;

   assign cw       = ucode_rom(step_ff);
   assign seq_idle = (step_ff == ST_IDLE);

   always_comb begin
      unique case (status.br_sel)
         BR_JUMP: branch_step = cw.jump_step;
         BR_ALT:  branch_step = cw.alt_step;
         default: branch_step = cw.next_step;
      endcase
   end

   always_comb begin
      step_in = step_ff;
      if (status.start_en) begin
         step_in = status.start_step;
      end else if (do_step) begin
         step_in = branch_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// ===== rtl/i2cm_dpath.sv =====
module i2cm_dpath (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         do_load,
   input  logic                         do_start,
   input  logic                         do_step,
   input  logic [i2cm_pkg::AddrW-1:0]   slave_addr,
   input  logic [i2cm_pkg::CountW-1:0]  write_count,
   input  logic [i2cm_pkg::CountW-1:0]  read_count,
   input  logic [i2cm_pkg::ByteW-1:0]   write_byte,
   input  logic                         sda_in,
   input  i2cm_pkg::ctrl_word_type      cw,
   input  logic                         seq_idle,
   output i2cm_pkg::dp_status_type      status,
   output i2cm_pkg::rsp_word_type       result
);
   import i2cm_pkg::*;

   logic [ByteW-1:0]   wbuf_mem [BufDepth];
   logic [ByteW-1:0]   rd_data_ff;
   logic               mem_we;

   logic [BitCntW-1:0] bit_cnt_ff, bit_cnt_in;
   logic [ByteW-1:0]   shift_ff, shift_in;
   logic [PtrW-1:0]    load_ptr_ff, load_ptr_in;
   logic [PtrW-1:0]    send_ptr_ff, send_ptr_in;
   logic [CountW-1:0]  out_left_ff, out_left_in;
   logic [CountW-1:0]  in_left_ff, in_left_in;
   logic [AddrW-1:0]   addr_ff, addr_in;
   logic               ack_ff, ack_in;
   logic               scl_lvl_ff, scl_lvl_in;
   logic               sda_lvl_ff, sda_lvl_in;

   logic [CountW-1:0]  wr_sat;
   logic [CountW-1:0]  in_dec;

   // buffer: loaded while idle, read one byte ahead of use
   always_ff @(posedge clock) begin
      if (mem_we) begin
         wbuf_mem[load_ptr_ff[BufIdxW-1:0]] <= write_byte;
      end
      rd_data_ff <= wbuf_mem[send_ptr_ff[BufIdxW-1:0]];
   end

   assign wr_sat = (int'(write_count) > BufDepth) ? CountW'(BufDepth) : write_count;
   assign in_dec = (in_left_ff != '0) ? in_left_ff - CountW'(1) : in_left_ff;

   always_comb begin
      mem_we      = 1'b0;
      bit_cnt_in  = bit_cnt_ff;
      shift_in    = shift_ff;
      load_ptr_in = load_ptr_ff;
      send_ptr_in = send_ptr_ff;
      out_left_in = out_left_ff;
      in_left_in  = in_left_ff;
      addr_in     = addr_ff;
      ack_in      = ack_ff;
      scl_lvl_in  = scl_lvl_ff;
      sda_lvl_in  = sda_lvl_ff;

      status.br_sel     = BR_NEXT;
      status.start_en   = 1'b0;
      status.start_step = ST_IDLE;

      result.rx_byte  = '0;
      result.rx_valid = 1'b0;
      result.done_res = 1'b0;
      result.nack     = 1'b0;

      if (do_load && seq_idle && int'(load_ptr_ff) < BufDepth) begin
         mem_we      = 1'b1;
         load_ptr_in = load_ptr_ff + PtrW'(1);
      end

      if (do_start && seq_idle) begin
         addr_in         = slave_addr;
         out_left_in     = wr_sat;
         in_left_in      = read_count;
         send_ptr_in     = '0;
         load_ptr_in     = '0;
         ack_in          = 1'b1;
         bit_cnt_in      = '0;
         status.start_en = 1'b1;
         if (wr_sat != '0) begin
            shift_in          = {slave_addr, 1'b0};
            status.start_step = ST_WBASE;
         end else if (read_count != '0) begin
            shift_in          = {slave_addr, 1'b1};
            status.start_step = ST_RBASE;
         end else begin
            status.start_step = ST_EMPTY;
         end
      end

      if (do_step) begin
         unique case (cw.scl)
            SCL_LOW:  scl_lvl_in = 1'b0;
            SCL_HIGH: scl_lvl_in = 1'b1;
            default:  ;
         endcase
         unique case (cw.sda)
            SDA_LOW:  sda_lvl_in = 1'b0;
            SDA_HIGH: sda_lvl_in = 1'b1;
            SDA_MSB:  sda_lvl_in = shift_ff[ByteW-1];
            default:  ;
         endcase

         unique case (cw.op)
            OP_EMPTY_DONE: begin
               result.done_res = 1'b1;
               result.nack     = ack_ff;
            end
            OP_BIT: begin
               shift_in = {shift_ff[ByteW-2:0], 1'b0};
               if (bit_cnt_ff == LAST_BIT) begin
                  bit_cnt_in    = '0;
                  status.br_sel = BR_JUMP;
               end else begin
                  bit_cnt_in = bit_cnt_ff + BitCntW'(1);
               end
            end
            OP_ACK_SAMPLE: ack_in = sda_in;
            OP_WR_DECIDE: begin
               if (!ack_ff && out_left_ff != '0) begin
                  shift_in      = rd_data_ff;
                  send_ptr_in   = send_ptr_ff + PtrW'(1);
                  out_left_in   = out_left_ff - CountW'(1);
                  status.br_sel = BR_JUMP;
               end else begin
                  out_left_in = '0;
               end
            end
            OP_RD_DECIDE: begin
               if (!ack_ff) begin
                  bit_cnt_in    = '0;
                  shift_in      = '0;
                  status.br_sel = BR_JUMP;
               end
            end
            OP_WR_STOP: begin
               if (in_left_ff != '0) begin
                  // repeated transaction in read direction
                  shift_in      = {addr_ff, 1'b1};
                  bit_cnt_in    = '0;
                  status.br_sel = BR_JUMP;
               end else begin
                  in_left_in      = '0;
                  result.done_res = 1'b1;
                  result.nack     = ack_ff;
               end
            end
            OP_RD_STOP: begin
               in_left_in      = '0;
               result.done_res = 1'b1;
               result.nack     = ack_ff;
            end
            OP_RX_SHIFT: shift_in = {shift_ff[ByteW-2:0], sda_in};
            OP_RX_BYTE: begin
               if (bit_cnt_ff == LAST_BIT) begin
                  bit_cnt_in      = '0;
                  result.rx_byte  = shift_ff;
                  result.rx_valid = 1'b1;
                  in_left_in      = in_dec;
                  status.br_sel   = (in_dec != '0) ? BR_JUMP : BR_NEXT;
               end else begin
                  bit_cnt_in    = bit_cnt_ff + BitCntW'(1);
                  status.br_sel = BR_ALT;
               end
            end
            default: ;
         endcase
      end

      result.scl_level = scl_lvl_in;
      result.sda_level = sda_lvl_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_cnt_ff  <= '0;
         shift_ff    <= '0;
         load_ptr_ff <= '0;
         send_ptr_ff <= '0;
         out_left_ff <= '0;
         in_left_ff  <= '0;
         addr_ff     <= '0;
         ack_ff      <= 1'b1;
         scl_lvl_ff  <= 1'b1;
         sda_lvl_ff  <= 1'b1;
      end else begin
         bit_cnt_ff  <= bit_cnt_in;
         shift_ff    <= shift_in;
         load_ptr_ff <= load_ptr_in;
         send_ptr_ff <= send_ptr_in;
         out_left_ff <= out_left_in;
         in_left_ff  <= in_left_in;
         addr_ff     <= addr_in;
         ack_ff      <= ack_in;
         scl_lvl_ff  <= scl_lvl_in;
         sda_lvl_ff  <= sda_lvl_in;
      end
   end

endmodule

// ===== rtl/i2c_master_transfer_engine_top.sv =====
// i2c master write-then-read transaction engine
// req_chan words: load a write byte into the buffer, start a transaction
// (address and byte counts), or advance the bus by one pin step with the
// sampled sda level. only bus-step words produce an rsp_chan word carrying
// the scl/sda drive levels, a received byte with rx_valid, and on the last
// step done_res with nack.
// the rsp word for a bus step is registered and valid in the cycle after the
// req word is accepted. one word per cycle is taken while req_chan is ready;
// each word is handled in a single pass through the control store read at the
// current step address. a stalled rsp_chan holds its word; req_chan stays
// ready while the output register is empty or being drained in the same cycle.
// reset: sequencer at idle, both pins released high, ack flag set, counters
// cleared. write buffer contents stay undefined until loaded.
// loads and starts while a transaction runs are dropped without a response.
module i2c_master_transfer_engine_top (
   input  logic           clock,
   input  logic           reset,
   i2cm_req_if.sink       req_chan,
   i2cm_rsp_if.source     rsp_chan
);
   import i2cm_pkg::*;

   logic          accept;
   logic          do_load;
   logic          do_start;
   logic          do_step;

   ctrl_word_type cw;
   logic          seq_idle;
   dp_status_type status;
   rsp_word_type  result;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_word_type  rsp_word_ff;

   // take a new word whenever the output slot is free or drains this cycle
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   // request decode
   assign do_load  = accept && (req_chan.req_type == REQ_LOAD);
   assign do_start = accept && (req_chan.req_type == REQ_START);
   assign do_step  = accept && (req_chan.req_type == REQ_BUS_STEP);

   // step counter and control store
   i2cm_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .do_step  (do_step),
      .status   (status),
      .cw       (cw),
      .seq_idle (seq_idle)
   );

   // pin, shift, counter and buffer datapath
   i2cm_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .do_load     (do_load),
      .do_start    (do_start),
      .do_step     (do_step),
      .slave_addr  (req_chan.slave_addr),
      .write_count (req_chan.write_count),
      .read_count  (req_chan.read_count),
      .write_byte  (req_chan.write_byte),
      .sda_in      (req_chan.sda_in),
      .cw          (cw),
      .seq_idle    (seq_idle),
      .status      (status),
      .result      (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (do_step) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (do_step) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.scl_level = rsp_word_ff.scl_level;
   assign rsp_chan.sda_level = rsp_word_ff.sda_level;
   assign rsp_chan.rx_byte   = rsp_word_ff.rx_byte;
   assign rsp_chan.rx_valid  = rsp_word_ff.rx_valid;
   assign rsp_chan.done_res  = rsp_word_ff.done_res;
   assign rsp_chan.nack      = rsp_word_ff.nack;

endmodule

// ===== sim/testbench.sv =====
module testbench;
   import i2cm_pkg::*;

   // req_type 3 has no meaning in the engine and must be dropped silently
   localparam logic [ReqTypeW-1:0] REQ_UNUSED = 2'd3;

   localparam int IdlePct     = 9;     // chance in a hundred of a gap or a stall
   localparam int StallLimit  = 600;   // cycles with no word moving on either channel
   localparam int RandomWords = 120;   // words the engine acts on in the random part
   localparam int MaxReported = 10;

   typedef struct packed {
      logic [ReqTypeW-1:0] kind;
      logic [AddrW-1:0]    addr;
      logic [CountW-1:0]   wcount;
      logic [CountW-1:0]   rcount;
      logic [ByteW-1:0]    data;
      logic                sda;
   } req_item_type;

   logic clock = 1'b0;
   logic reset;

   i2cm_req_if req_bus();
   i2cm_rsp_if rsp_bus();

   i2c_master_transfer_engine_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // engine mirror: sequencer position, shifter, buffer and counters
   // ------------------------------------------------------------------
   logic [StepW-1:0]   eng_step;
   logic [BitCntW-1:0] eng_bit;
   logic [ByteW-1:0]   eng_shift;
   logic [ByteW-1:0]   eng_buf [BufDepth];
   int unsigned        eng_load_ptr;
   int unsigned        eng_send_ptr;
   logic [CountW-1:0]  eng_out_left;
   logic [CountW-1:0]  eng_in_left;
   logic [AddrW-1:0]   eng_addr;
   logic               eng_ack;
   logic               eng_scl;
   logic               eng_sda;

   // pin levels and status the engine owes us, oldest first
   rsp_word_type pending_rsp_q[$];

   bit calm;            // no gaps and no stalls while set
   int words_taken;     // words that changed the engine or produced a rsp word
   int txn_count;
   int checked_count;
   int rx_count;
   int nack_done_count;
   int mismatches;
   int idle_cycles = 0;

   // address byte with the read bit, then the read-side segment
   task automatic begin_read_phase();
      eng_shift = {eng_addr, 1'b1};
      eng_bit   = '0;
      eng_step  = ST_RBASE;
   endtask

   // apply one accepted word to the mirror; a bus step queues its rsp word
   task automatic advance_engine(input req_item_type w, output bit taken);
      logic [StepW-1:0] base;
      logic [StepW-1:0] ofs;
      rsp_word_type     r;
      r     = '0;
      taken = 1'b0;
      if (w.kind == REQ_LOAD) begin
         // loads count only while idle and while the buffer has room
         if (eng_step == ST_IDLE && eng_load_ptr < BufDepth) begin
            eng_buf[eng_load_ptr] = w.data;
            eng_load_ptr++;
            taken = 1'b1;
         end
      end else if (w.kind == REQ_START) begin
         if (eng_step == ST_IDLE) begin
            taken        = 1'b1;
            eng_addr     = w.addr;
            // write count saturates at the buffer depth
            eng_out_left = (w.wcount > BufDepth) ? CountW'(BufDepth) : w.wcount;
            eng_in_left  = w.rcount;
            eng_send_ptr = 0;
            eng_load_ptr = 0;
            eng_ack      = 1'b1;
            eng_bit      = '0;
            if (eng_out_left != 0) begin
               eng_shift = {eng_addr, 1'b0};
               eng_step  = ST_WBASE;
            end else if (eng_in_left != 0) begin
               begin_read_phase();
            end else begin
               eng_step = ST_EMPTY;
            end
         end
      end else if (w.kind == REQ_BUS_STEP) begin
         taken = 1'b1;
         if (eng_step == ST_EMPTY) begin
            // nothing to move: report done with nack, pins untouched
            r.done_res = 1'b1;
            r.nack     = eng_ack;
            eng_step   = ST_IDLE;
         end else if (eng_step >= ST_WBASE && eng_step < ST_RXH) begin
            base = (eng_step >= ST_RBASE) ? ST_RBASE : ST_WBASE;
            ofs  = eng_step - base;
            case (ofs)
               OFS_SDA_HI: begin
                  eng_sda  = 1'b1;
                  eng_step = eng_step + StepW'(1);
               end
               OFS_SCL_HI: begin
                  eng_scl  = 1'b1;
                  eng_step = eng_step + StepW'(1);
               end
               OFS_START: begin
                  eng_sda  = 1'b0;
                  eng_step = eng_step + StepW'(1);
               end
               OFS_START_SCL: begin
                  eng_scl  = 1'b0;
                  eng_step = eng_step + StepW'(1);
               end
               OFS_BIT_SDA: begin
                  eng_sda  = eng_shift[ByteW-1];
                  eng_step = eng_step + StepW'(1);
               end
               OFS_BIT_SCL_HI: begin
                  eng_scl  = 1'b1;
                  eng_step = eng_step + StepW'(1);
               end
               OFS_BIT_SCL_LO: begin
                  eng_scl   = 1'b0;
                  eng_shift = eng_shift << 1;
                  if (eng_bit == LAST_BIT) begin
                     eng_bit  = '0;
                     eng_step = base + OFS_ACK_REL;
                  end else begin
                     eng_bit  = eng_bit + BitCntW'(1);
                     eng_step = base + OFS_BIT_SDA;
                  end
               end
               OFS_ACK_REL: begin
                  eng_sda  = 1'b1;
                  eng_step = eng_step + StepW'(1);
               end
               OFS_ACK_SCL_HI: begin
                  eng_scl  = 1'b1;
                  eng_ack  = w.sda;
                  eng_step = eng_step + StepW'(1);
               end
               OFS_ACK_SCL_LO: begin
                  eng_scl = 1'b0;
                  if (base == ST_WBASE) begin
                     if (eng_ack == 1'b0 && eng_out_left != 0) begin
                        eng_shift    = eng_buf[eng_send_ptr];
                        eng_send_ptr++;
                        eng_out_left = eng_out_left - CountW'(1);
                        eng_step     = base + OFS_BIT_SDA;
                     end else begin
                        // nack or last byte: go to stop
                        eng_out_left = '0;
                        eng_step     = base + OFS_STOP_SCL_LO;
                     end
                  end else if (eng_ack == 1'b0) begin
                     eng_bit   = '0;
                     eng_shift = '0;
                     eng_step  = ST_RXH;
                  end else begin
                     // read address not acknowledged: no data, nak and stop
                     eng_step = ST_NAK_SDA;
                  end
               end
               OFS_STOP_SCL_LO: begin
                  eng_scl  = 1'b0;
                  eng_step = eng_step + StepW'(1);
               end
               OFS_STOP_SDA_LO: begin
                  eng_sda  = 1'b0;
                  eng_step = eng_step + StepW'(1);
               end
               OFS_STOP_SCL_HI: begin
                  eng_scl  = 1'b1;
                  eng_step = eng_step + StepW'(1);
               end
               default: begin
                  // stop complete; the read phase runs even after a write nack
                  eng_sda = 1'b1;
                  if (base == ST_WBASE && eng_in_left != 0) begin
                     begin_read_phase();
                  end else begin
                     eng_in_left = '0;
                     eng_step    = ST_IDLE;
                     r.done_res  = 1'b1;
                     r.nack      = eng_ack;
                  end
               end
            endcase
         end else if (eng_step == ST_RXH) begin
            eng_scl   = 1'b1;
            eng_shift = {eng_shift[ByteW-2:0], w.sda};
            eng_step  = ST_RXL;
         end else if (eng_step == ST_RXL) begin
            eng_scl = 1'b0;
            if (eng_bit == LAST_BIT) begin
               eng_bit    = '0;
               r.rx_byte  = eng_shift;
               r.rx_valid = 1'b1;
               if (eng_in_left != 0) eng_in_left = eng_in_left - CountW'(1);
               eng_step = (eng_in_left != 0) ? ST_ACK_SDA : ST_NAK_SDA;
            end else begin
               eng_bit  = eng_bit + BitCntW'(1);
               eng_step = ST_RXH;
            end
         end else if (eng_step >= ST_ACK_SDA && eng_step <= ST_ACK_REL) begin
            // master ack after a byte that is not the last
            case (eng_step)
               ST_ACK_SDA:    eng_sda = 1'b0;
               ST_ACK_SCL_HI: eng_scl = 1'b1;
               ST_ACK_SCL_LO: eng_scl = 1'b0;
               default:       eng_sda = 1'b1;
            endcase
            eng_step = (eng_step == ST_ACK_REL) ? ST_RXH : eng_step + StepW'(1);
         end else if (eng_step >= ST_NAK_SDA && eng_step <= ST_NAK_REL) begin
            // master nak, then the read-side stop
            case (eng_step)
               ST_NAK_SCL_HI: eng_scl = 1'b1;
               ST_NAK_SCL_LO: eng_scl = 1'b0;
               default:       eng_sda = 1'b1;
            endcase
            eng_step = (eng_step == ST_NAK_REL) ? ST_RD_STOP : eng_step + StepW'(1);
         end else begin
            // idle: just report the current pins
            eng_step = ST_IDLE;
         end
         r.scl_level = eng_scl;
         r.sda_level = eng_sda;
         pending_rsp_q.push_back(r);
      end
   endtask

   // ------------------------------------------------------------------
   // rsp side: compare each accepted word with the oldest expectation,
   // then pick the next ready level
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_word_type got;
      rsp_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.scl_level = rsp_bus.scl_level;
         got.sda_level = rsp_bus.sda_level;
         got.rx_byte   = rsp_bus.rx_byte;
         got.rx_valid  = rsp_bus.rx_valid;
         got.done_res  = rsp_bus.done_res;
         got.nack      = rsp_bus.nack;
         checked_count++;
         if (pending_rsp_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MaxReported)
               $display("rsp word %0d arrived with nothing pending: scl=%0b sda=%0b",
                        checked_count, got.scl_level, got.sda_level,
                        " rx_byte=%02h rx_valid=%0b done=%0b nack=%0b",
                        got.rx_byte, got.rx_valid, got.done_res, got.nack);
         end else begin
            want = pending_rsp_q.pop_front();
            if (want.rx_valid) rx_count++;
            if (want.done_res && want.nack) nack_done_count++;
            if (got.scl_level !== want.scl_level || got.sda_level !== want.sda_level ||
                got.rx_byte !== want.rx_byte || got.rx_valid !== want.rx_valid ||
                got.done_res !== want.done_res || got.nack !== want.nack) begin
               mismatches++;
               if (mismatches <= MaxReported)
                  $display("rsp word %0d mismatch: expected scl=%0b sda=%0b",
                           checked_count, want.scl_level, want.sda_level,
                           " rx_byte=%02h rx_valid=%0b done=%0b nack=%0b,",
                           want.rx_byte, want.rx_valid, want.done_res, want.nack,
                           " got scl=%0b sda=%0b", got.scl_level, got.sda_level,
                           " rx_byte=%02h rx_valid=%0b done=%0b nack=%0b",
                           got.rx_byte, got.rx_valid, got.done_res, got.nack);
            end
         end
      end
      rsp_bus.ready <= calm || ($urandom_range(99) >= IdlePct);
   end

   // watchdog: a word must move on one channel or the other
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
         $display("no word moved for %0d cycles, %0d rsp words still pending",
                  idle_cycles, pending_rsp_q.size());
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // req side
   // ------------------------------------------------------------------
   // every field random; callers overwrite the ones that matter
   function automatic req_item_type random_word(input logic [ReqTypeW-1:0] kind);
      req_item_type w;
      w.kind   = kind;
      w.addr   = AddrW'($urandom);
      w.wcount = CountW'($urandom);
      w.rcount = CountW'($urandom);
      w.data   = ByteW'($urandom);
      w.sda    = 1'($urandom_range(1));
      return w;
   endfunction

   // drive one word and wait for the handshake; valid stays up afterwards
   // so back-to-back words need no second assignment in the same step
   task automatic send_word(input req_item_type w);
      bit taken;
      while (!calm && $urandom_range(99) < IdlePct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.req_type    <= w.kind;
      req_bus.slave_addr  <= w.addr;
      req_bus.write_count <= w.wcount;
      req_bus.read_count  <= w.rcount;
      req_bus.write_byte  <= w.data;
      req_bus.sda_in      <= w.sda;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      advance_engine(w, taken);
      if (taken) words_taken++;
   endtask

   task automatic load_byte(input logic [ByteW-1:0] value);
      req_item_type w;
      w      = random_word(REQ_LOAD);
      w.data = value;
      send_word(w);
   endtask

   task automatic idle_step(input logic sda);
      req_item_type w;
      w     = random_word(REQ_BUS_STEP);
      w.sda = sda;
      send_word(w);
   endtask

   // start a transaction and step the bus until the engine is idle again;
   // the ack sample numbered nack_at is answered with a nack, the others
   // nack with miss_pct chance; noise_pct drops in words the engine must ignore
   task automatic run_transaction(input logic [AddrW-1:0] addr,
                                  input logic [CountW-1:0] wcount,
                                  input logic [CountW-1:0] rcount,
                                  input int nack_at, input int miss_pct,
                                  input int noise_pct);
      req_item_type w;
      int        ack_idx;
      logic [ReqTypeW-1:0] noise_kind;
      ack_idx  = 0;
      w        = random_word(REQ_START);
      w.addr   = addr;
      w.wcount = wcount;
      w.rcount = rcount;
      send_word(w);
      txn_count++;
      while (eng_step != ST_IDLE) begin
         if ($urandom_range(99) < noise_pct) begin
            case ($urandom_range(2))
               0:       noise_kind = REQ_LOAD;
               1:       noise_kind = REQ_START;
               default: noise_kind = REQ_UNUSED;
            endcase
            send_word(random_word(noise_kind));
         end
         w = random_word(REQ_BUS_STEP);
         if (eng_step == (ST_WBASE + OFS_ACK_SCL_HI) ||
             eng_step == (ST_RBASE + OFS_ACK_SCL_HI)) begin
            // slave ack slot: mostly acknowledge to get deep into the transfer
            w.sda = (ack_idx == nack_at) || ($urandom_range(99) < miss_pct);
            ack_idx++;
         end
         send_word(w);
      end
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp_q.size() != 0) @(posedge clock);
      // rsp word is registered behind its req word; a little margin
      repeat (4) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   // bus steps while idle, a type 3 word, buffer fill and a load into a full buffer
   task automatic test_idle_and_buffer();
      idle_step(1'b0);
      idle_step(1'b1);
      send_word(random_word(REQ_UNUSED));
      load_byte(8'h00);
      load_byte(8'hFF);
      load_byte(8'h80);
      load_byte(8'h01);
      // fill every entry so no later transfer reads an unloaded one
      for (int i = 4; i < BufDepth; i++) load_byte(ByteW'($urandom));
      load_byte(8'hA5);
      idle_step(1'b1);
   endtask

   // start with both counts zero: one step, done with nack
   task automatic test_empty_transaction();
      run_transaction(7'h7F, 5'd0, 5'd0, -1, 0, 0);
      run_transaction(7'h00, 5'd0, 5'd0, -1, 0, 0);
   endtask

   task automatic test_write_only();
      run_transaction(7'h55, 5'd2, 5'd0, -1, 0, 0);
   endtask

   // write count past the buffer depth sends the whole buffer, no more;
   // this long transfer runs without gaps or stalls
   task automatic test_write_saturated();
      calm = 1'b1;
      run_transaction(7'h2A, 5'd31, 5'd0, -1, 0, 0);
      calm = 1'b0;
   endtask

   task automatic test_read_only();
      run_transaction(7'h3C, 5'd0, 5'd3, -1, 0, 0);
   endtask

   // address nack on each side, and a data nack that still leads to a read
   task automatic test_nack_paths();
      run_transaction(7'h11, 5'd3, 5'd0, 0, 0, 0);
      run_transaction(7'h6E, 5'd0, 5'd31, 0, 0, 0);
      run_transaction(7'h33, 5'd16, 5'd2, 1, 0, 0);
      run_transaction(7'h4B, 5'd1, 5'd1, 2, 0, 0);
   endtask

   // loads, starts and type 3 words during a transfer are dropped
   task automatic test_busy_requests();
      load_byte(ByteW'($urandom));
      load_byte(ByteW'($urandom));
      run_transaction(AddrW'($urandom), 5'd2, 5'd2, -1, 0, 40);
      load_byte(ByteW'($urandom));
      run_transaction(AddrW'($urandom), 5'd1, 5'd1, -1, 0, 0);
   endtask

   // mostly well-formed transfers with random content, some noise,
   // small sizes most of the time and any size up to the largest now and then
   task automatic test_random_traffic();
      int                first;
      int                nloads;
      logic [CountW-1:0] wc;
      logic [CountW-1:0] rc;
      first = words_taken;
      while (words_taken - first < RandomWords) begin
         case ($urandom_range(19))
            0: idle_step(1'($urandom_range(1)));
            1: send_word(random_word(REQ_UNUSED));
            2: run_transaction(AddrW'($urandom), 5'd0, 5'd0, -1, 0, 0);
            default: begin
               nloads = $urandom_range(4);
               for (int i = 0; i < nloads; i++) load_byte(ByteW'($urandom));
               if ($urandom_range(24) == 0) begin
                  wc = CountW'($urandom_range(31));
                  rc = CountW'($urandom_range(31));
               end else begin
                  wc = CountW'($urandom_range(4));
                  rc = CountW'($urandom_range(4));
               end
               run_transaction(AddrW'($urandom), wc, rc, -1, 6, 3);
            end
         endcase
      end
   endtask

   // ------------------------------------------------------------------
   // run
   // ------------------------------------------------------------------
   initial begin
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.req_type    <= REQ_LOAD;
      req_bus.slave_addr  <= '0;
      req_bus.write_count <= '0;
      req_bus.read_count  <= '0;
      req_bus.write_byte  <= '0;
      req_bus.sda_in      <= 1'b1;

      // mirror starts from the reset state
      eng_step     = ST_IDLE;
      eng_bit      = '0;
      eng_shift    = '0;
      eng_load_ptr = 0;
      eng_send_ptr = 0;
      eng_out_left = '0;
      eng_in_left  = '0;
      eng_addr     = '0;
      eng_ack      = 1'b1;
      eng_scl      = 1'b1;
      eng_sda      = 1'b1;
      for (int i = 0; i < BufDepth; i++) eng_buf[i] = '0;
      calm            = 1'b0;
      words_taken     = 0;
      txn_count       = 0;
      checked_count   = 0;
      rx_count        = 0;
      nack_done_count = 0;
      mismatches      = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_idle_and_buffer();
      wait_drained();
      test_empty_transaction();
      wait_drained();
      test_write_only();
      wait_drained();
      test_write_saturated();
      wait_drained();
      test_read_only();
      wait_drained();
      test_nack_paths();
      wait_drained();
      test_busy_requests();
      wait_drained();
      test_random_traffic();
      wait_drained();

      $display("ran %0d transactions over %0d req words, checked %0d rsp words",
               txn_count, words_taken, checked_count);
      $display("received %0d bytes, %0d transactions ended with nack, %0d mismatches",
               rx_count, nack_done_count, mismatches);
      if (mismatches == 0 && pending_rsp_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/i2cm_pkg.sv
rtl/i2cm_ifs.sv
rtl/i2cm_seq.sv
rtl/i2cm_dpath.sv
rtl/i2c_master_transfer_engine_top.sv
sim/testbench.sv
